FILE: sv/lt_pkg.sv
package lt_pkg;

    // Column limit of a line, columns saturate at min(LINE_MAX-1, 255)
    localparam int LINE_MAX = 256;
    localparam int COL_W    = 8;
    localparam int COL_MAX  = (LINE_MAX - 1 < 255) ? LINE_MAX - 1 : 255;
    localparam int LEN_W    = COL_W + 1;

    // Identifier capture and keyword table
    localparam int WORD_MAX  = 5;
    localparam int WCNT_W    = $clog2(WORD_MAX + 2);
    localparam int NUM_WORDS = 10;
    localparam int LAST_KW   = 7;

    // Token queue between scanner and output stage
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [3:0] {
        CAT_KEYWORD  = 4'd0,
        CAT_IDENT    = 4'd1,
        CAT_STRING   = 4'd2,
        CAT_NUMBER   = 4'd3,
        CAT_ASSIGN   = 4'd4,
        CAT_ARITH    = 4'd5,
        CAT_LOGICAL  = 4'd6,
        CAT_RELATION = 4'd7,
        CAT_LPAREN   = 4'd8,
        CAT_RPAREN   = 4'd9,
        CAT_COLON    = 4'd10,
        CAT_COMMA    = 4'd11,
        CAT_COMMENT  = 4'd12,
        CAT_INDENT   = 4'd13,
        CAT_UNKNOWN  = 4'd14
    } t_cat;

    typedef enum logic [6:0] {
        M_IDLE = 7'b0000001,
        M_NUM  = 7'b0000010,
        M_WORD = 7'b0000100,
        M_STR  = 7'b0001000,
        M_REM  = 7'b0010000,
        M_IND  = 7'b0100000,
        M_OP   = 7'b1000000
    } t_mode;

    // Characters with a meaning of their own
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam logic [7:0] WORD_TAB [NUM_WORDS][WORD_MAX] = '{
        '{8'h70, 8'h72, 8'h69, 8'h6E, 8'h74},  // print
        '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00},  // if
        '{8'h65, 8'h6C, 8'h69, 8'h66, 8'h00},  // elif
        '{8'h65, 8'h6C, 8'h73, 8'h65, 8'h00},  // else
        '{8'h77, 8'h68, 8'h69, 8'h6C, 8'h65},  // while
        '{8'h69, 8'h6E, 8'h70, 8'h75, 8'h74},  // input
        '{8'h69, 8'h6E, 8'h74, 8'h00, 8'h00},  // int
        '{8'h61, 8'h6E, 8'h64, 8'h00, 8'h00},  // and
        '{8'h6F, 8'h72, 8'h00, 8'h00, 8'h00},  // or
        '{8'h6E, 8'h6F, 8'h74, 8'h00, 8'h00}   // not
    };

    localparam logic [WCNT_W-1:0] WORD_LEN [NUM_WORDS] = '{
        WCNT_W'(5), WCNT_W'(2), WCNT_W'(4), WCNT_W'(4), WCNT_W'(5),
        WCNT_W'(5), WCNT_W'(3), WCNT_W'(3), WCNT_W'(2), WCNT_W'(3)
    };

    typedef struct packed {
        logic [7:0] ch;
        logic       line_end;
    } t_in;

    typedef struct packed {
        t_cat             category;
        logic [COL_W-1:0] start_col;
        logic [LEN_W-1:0] tok_len;
        logic [3:0]       word_index;
        logic             end_of_line;
        logic             last_of_run;
    } t_tok;

    // Tokens caused by one character; b is used only when two is set
    typedef struct packed {
        logic two;
        t_tok a;
        t_tok b;
    } t_pair;

    typedef struct packed {
        logic  valid;
        t_pair data;
    } t_qhead;

    // Keyword table lookup, zero when the word is not in the table
    function automatic logic [3:0] word_lookup(
        input logic [WORD_MAX-1:0][7:0] wbuf,
        input logic [WCNT_W-1:0]        cnt
    );
        logic [3:0] idx;
        logic       same;
        idx = 4'd0;
        for (int k = 0; k < NUM_WORDS; k++) begin
            same = (WORD_LEN[k] == cnt);
            for (int j = 0; j < WORD_MAX; j++) begin
                if ((WCNT_W'(j) < cnt) && (WORD_TAB[k][j] != wbuf[j])) begin
                    same = 1'b0;
                end
            end
            if (same && (idx == 4'd0)) begin
                idx = 4'(k + 1);
            end
        end
        return idx;
    endfunction

endpackage

FILE: sv/line_tokenizer_core.sv
// Line tokenizer: turns a stream of source bytes into tokens.
// Input channel (i_in_valid / o_in_ready / i_in_data) moves one character per
// beat, with line_end set on the last character of each line. Output channel
// (o_out_valid / i_out_ready / o_out_data) moves one token per beat: category,
// start column, length, keyword index, end_of_line and last_of_run.
// A character causes zero, one or two tokens. The scanner takes one character
// every cycle while the queue is not full, and writes the tokens it causes as
// one entry of a four-entry queue; the output stage drains one token per cycle
// into an output register while the receiver is ready. The first token of a
// character passes through the queue entry and then the output register before
// it shows on o_out_valid; the second token follows it. Throughput is one
// character per cycle and one token per cycle; the output register port sets
// the limit when characters cause two tokens each.
// A token appears only once its last character is known, so a run or a
// possible two-character operator is reported on the next character or at
// the line end.
// When the receiver stalls, the output holds, the queue fills and o_in_ready
// drops once all four entries are taken. Reset (synchronous, active low)
// empties the queue, drops o_out_valid and returns the scanner to column 0
// with no open token.
module line_tokenizer_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  lt_pkg::t_in  i_in_data,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output lt_pkg::t_tok o_out_data
);

    logic           q_push, q_pop, q_full;
    lt_pkg::t_pair  q_push_data;
    lt_pkg::t_qhead q_head;

    // Scanner: classify each character and close tokens
    lt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .i_data      (i_in_data),
        .i_q_full    (q_full),
        .o_ready     (o_in_ready),
        .o_push      (q_push),
        .o_push_data (q_push_data)
    );

    // Decouple scanner and output so each can stall on its own
    lt_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .i_pop       (q_pop),
        .o_full      (q_full),
        .o_head      (q_head)
    );

    // Output stage: split token pairs, one beat per token
    lt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (q_head),
        .i_ready (i_out_ready),
        .o_pop   (q_pop),
        .o_valid (o_out_valid),
        .o_data  (o_out_data)
    );

endmodule

FILE: sv/lt_front.sv
module lt_front (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  lt_pkg::t_in  i_data,
    input  logic         i_q_full,
    output logic         o_ready,
    output logic         o_push,
    output lt_pkg::t_pair o_push_data
);

    typedef struct packed {
        logic         v;
        lt_pkg::t_tok tok;
    } t_ev;

    lt_pkg::t_mode r_mode, n_mode, mode2;
    logic [lt_pkg::WORD_MAX-1:0][7:0] r_wbuf, n_wbuf;
    logic [lt_pkg::WCNT_W-1:0] r_wcount, n_wcount;
    logic [7:0] r_quote, n_quote;
    logic [7:0] r_op, n_op;
    logic [lt_pkg::COL_W-1:0] r_ts, n_ts;
    logic [lt_pkg::COL_W-1:0] r_column, n_column;

    logic [lt_pkg::COL_W-1:0] cur, prev;
    logic [7:0] c;
    logic       le, used, accept;
    logic       is_digit, is_alpha, is_wordch, is_ws;
    logic [3:0] widx_old, widx_new;
    t_ev        ev1, ev2, ev3, ev23;

    function automatic lt_pkg::t_tok mk_tok(
        input lt_pkg::t_cat cat,
        input logic [lt_pkg::COL_W-1:0] start,
        input logic [lt_pkg::LEN_W-1:0] len,
        input logic [3:0] idx
    );
        lt_pkg::t_tok t;
        t.category    = cat;
        t.start_col   = start;
        t.tok_len     = len;
        t.word_index  = idx;
        t.end_of_line = 1'b0;
        t.last_of_run = 1'b0;
        return t;
    endfunction

    // Close the open token whose last character sits at column last
    function automatic t_ev flush_tok(
        input lt_pkg::t_mode mode,
        input logic [lt_pkg::COL_W-1:0] ts,
        input logic [lt_pkg::COL_W-1:0] last,
        input logic [7:0] op,
        input logic [3:0] widx
    );
        t_ev e;
        logic [lt_pkg::LEN_W-1:0] len;
        lt_pkg::t_cat wcat;
        lt_pkg::t_cat ocat;
        len = (last >= ts) ? ({1'b0, last} - {1'b0, ts} + lt_pkg::LEN_W'(1))
                           : lt_pkg::LEN_W'(1);
        wcat = (widx == 4'd0) ? lt_pkg::CAT_IDENT :
               ((widx <= 4'(lt_pkg::LAST_KW)) ? lt_pkg::CAT_KEYWORD : lt_pkg::CAT_LOGICAL);
        ocat = (op == lt_pkg::CH_EQ) ? lt_pkg::CAT_ASSIGN :
               ((op == lt_pkg::CH_BANG) ? lt_pkg::CAT_UNKNOWN : lt_pkg::CAT_RELATION);
        e = '0;
        e.v = 1'b1;
        unique case (mode)
            lt_pkg::M_NUM:  e.tok = mk_tok(lt_pkg::CAT_NUMBER, ts, len, 4'd0);
            lt_pkg::M_WORD: e.tok = mk_tok(wcat, ts, len, widx);
            lt_pkg::M_STR:  e.tok = mk_tok(lt_pkg::CAT_STRING, ts, len, 4'd0);
            lt_pkg::M_REM:  e.tok = mk_tok(lt_pkg::CAT_COMMENT, ts, len, 4'd0);
            lt_pkg::M_IND:  e.tok = mk_tok(lt_pkg::CAT_INDENT, ts, len, 4'd0);
            lt_pkg::M_OP:   e.tok = mk_tok(ocat, ts, lt_pkg::LEN_W'(1), 4'd0);
            default:        e.v = 1'b0;
        endcase
        return e;
    endfunction

    assign c  = i_data.ch;
    assign le = i_data.line_end;

    assign is_digit  = (c >= 8'h30) && (c <= 8'h39);
    assign is_alpha  = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    assign is_wordch = is_alpha || is_digit || (c == lt_pkg::CH_UNDER);
    assign is_ws     = (c == lt_pkg::CH_SPACE) || ((c >= lt_pkg::CH_TAB) && (c <= lt_pkg::CH_CR));

    assign cur  = r_column;
    assign prev = (cur > r_ts) ? cur - lt_pkg::COL_W'(1) : r_ts;

    assign widx_old = lt_pkg::word_lookup(r_wbuf, r_wcount);

    // Continue or close the open token, then start a new one
    always_comb begin
        used     = 1'b0;
        mode2    = r_mode;
        ev1      = '0;
        ev2      = '0;
        n_wbuf   = r_wbuf;
        n_wcount = r_wcount;
        n_quote  = r_quote;
        n_op     = r_op;
        n_ts     = r_ts;

        unique case (r_mode)
            lt_pkg::M_NUM: begin
                if (is_digit) begin
                    used = 1'b1;
                end else begin
                    ev1   = flush_tok(r_mode, r_ts, prev, r_op, widx_old);
                    mode2 = lt_pkg::M_IDLE;
                end
            end
            lt_pkg::M_WORD: begin
                if (is_wordch) begin
                    used = 1'b1;
                    if (r_wcount < lt_pkg::WCNT_W'(lt_pkg::WORD_MAX)) begin
                        n_wbuf[r_wcount] = c;
                    end
                    if (r_wcount < lt_pkg::WCNT_W'(lt_pkg::WORD_MAX + 1)) begin
                        n_wcount = r_wcount + lt_pkg::WCNT_W'(1);
                    end
                end else begin
                    ev1   = flush_tok(r_mode, r_ts, prev, r_op, widx_old);
                    mode2 = lt_pkg::M_IDLE;
                end
            end
            lt_pkg::M_STR: begin
                used = 1'b1;
                if (c == r_quote) begin
                    ev1   = flush_tok(r_mode, r_ts, cur, r_op, widx_old);
                    mode2 = lt_pkg::M_IDLE;
                end
            end
            lt_pkg::M_REM: begin
                used = 1'b1;
            end
            lt_pkg::M_IND: begin
                if (is_ws) begin
                    used = 1'b1;
                end else begin
                    ev1   = flush_tok(r_mode, r_ts, prev, r_op, widx_old);
                    mode2 = lt_pkg::M_IDLE;
                end
            end
            lt_pkg::M_OP: begin
                mode2 = lt_pkg::M_IDLE;
                if (c == lt_pkg::CH_EQ) begin
                    used    = 1'b1;
                    ev1.v   = 1'b1;
                    ev1.tok = mk_tok(lt_pkg::CAT_RELATION, r_ts, lt_pkg::LEN_W'(2), 4'd0);
                end else begin
                    ev1 = flush_tok(r_mode, r_ts, prev, r_op, widx_old);
                end
            end
            default: begin
                mode2 = lt_pkg::M_IDLE;
            end
        endcase

        if (!used) begin
            priority if (is_digit) begin
                mode2 = lt_pkg::M_NUM;
                n_ts  = cur;
            end else if (is_alpha || (c == lt_pkg::CH_UNDER)) begin
                mode2     = lt_pkg::M_WORD;
                n_ts      = cur;
                n_wbuf[0] = c;
                n_wcount  = lt_pkg::WCNT_W'(1);
            end else if ((c == lt_pkg::CH_DQUOTE) || (c == lt_pkg::CH_SQUOTE)) begin
                mode2   = lt_pkg::M_STR;
                n_ts    = cur;
                n_quote = c;
            end else if (c == lt_pkg::CH_LPAREN) begin
                ev2.v   = 1'b1;
                ev2.tok = mk_tok(lt_pkg::CAT_LPAREN, cur, lt_pkg::LEN_W'(1), 4'd0);
            end else if (c == lt_pkg::CH_RPAREN) begin
                ev2.v   = 1'b1;
                ev2.tok = mk_tok(lt_pkg::CAT_RPAREN, cur, lt_pkg::LEN_W'(1), 4'd0);
            end else if (c == lt_pkg::CH_COLON) begin
                ev2.v   = 1'b1;
                ev2.tok = mk_tok(lt_pkg::CAT_COLON, cur, lt_pkg::LEN_W'(1), 4'd0);
            end else if (c == lt_pkg::CH_COMMA) begin
                ev2.v   = 1'b1;
                ev2.tok = mk_tok(lt_pkg::CAT_COMMA, cur, lt_pkg::LEN_W'(1), 4'd0);
            end else if (c == lt_pkg::CH_HASH) begin
                mode2 = lt_pkg::M_REM;
                n_ts  = cur;
            end else if (is_ws) begin
                if (cur == '0) begin
                    mode2 = lt_pkg::M_IND;
                    n_ts  = cur;
                end
            end else if ((c == lt_pkg::CH_PLUS) || (c == lt_pkg::CH_MINUS) ||
                         (c == lt_pkg::CH_STAR) || (c == lt_pkg::CH_SLASH) ||
                         (c == lt_pkg::CH_PCT)) begin
                ev2.v   = 1'b1;
                ev2.tok = mk_tok(lt_pkg::CAT_ARITH, cur, lt_pkg::LEN_W'(1), 4'd0);
            end else if ((c == lt_pkg::CH_LT) || (c == lt_pkg::CH_GT) ||
                         (c == lt_pkg::CH_EQ) || (c == lt_pkg::CH_BANG)) begin
                mode2 = lt_pkg::M_OP;
                n_ts  = cur;
                n_op  = c;
            end else begin
                ev2.v   = 1'b1;
                ev2.tok = mk_tok(lt_pkg::CAT_UNKNOWN, cur, lt_pkg::LEN_W'(1), 4'd0);
            end
        end
    end

    assign widx_new = lt_pkg::word_lookup(n_wbuf, n_wcount);

    // Line end closes whatever is still open
    always_comb begin
        ev3 = '0;
        if (le) begin
            ev3 = flush_tok(mode2, n_ts, cur, n_op, widx_new);
        end
        n_mode   = le ? lt_pkg::M_IDLE : mode2;
        n_column = le ? '0 :
                   ((cur < lt_pkg::COL_W'(lt_pkg::COL_MAX)) ? cur + lt_pkg::COL_W'(1)
                                                             : lt_pkg::COL_W'(lt_pkg::COL_MAX));
    end

    // Pack up to two tokens in order and flag the last one
    always_comb begin
        ev23 = ev2.v ? ev2 : ev3;
        o_push_data     = '0;
        o_push_data.two = ev1.v && ev23.v;
        o_push_data.a   = ev1.v ? ev1.tok : ev23.tok;
        o_push_data.b   = ev23.tok;
        if (o_push_data.two) begin
            o_push_data.b.last_of_run = 1'b1;
            o_push_data.b.end_of_line = le;
        end else begin
            o_push_data.a.last_of_run = 1'b1;
            o_push_data.a.end_of_line = le;
        end
    end

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && (ev1.v || ev23.v);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= lt_pkg::M_IDLE;
            r_wcount <= '0;
            r_quote  <= '0;
            r_op     <= '0;
            r_ts     <= '0;
            r_column <= '0;
        end else if (accept) begin
            r_mode   <= n_mode;
            r_wcount <= n_wcount;
            r_quote  <= n_quote;
            r_op     <= n_op;
            r_ts     <= n_ts;
            r_column <= n_column;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_wbuf <= n_wbuf;
        end
    end

endmodule

FILE: sv/lt_queue.sv
module lt_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lt_pkg::t_pair i_push_data,
    input  logic          i_pop,
    output logic          o_full,
    output lt_pkg::t_qhead o_head
);

    lt_pkg::t_pair r_mem [lt_pkg::Q_DEPTH];
    logic [lt_pkg::Q_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [lt_pkg::Q_CNT_W-1:0] r_count;
    logic do_push, do_pop;

    assign o_full      = (r_count == lt_pkg::Q_CNT_W'(lt_pkg::Q_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.data  = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + lt_pkg::Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + lt_pkg::Q_PTR_W'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + lt_pkg::Q_CNT_W'(1);
                2'b01:   r_count <= r_count - lt_pkg::Q_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

FILE: sv/lt_back.sv
module lt_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lt_pkg::t_qhead i_head,
    input  logic           i_ready,
    output logic           o_pop,
    output logic           o_valid,
    output lt_pkg::t_tok   o_data
);

    logic         r_valid;
    logic         r_sel, n_sel;
    lt_pkg::t_tok r_data;
    logic         load;

    // Refill the output register whenever it is empty or being drained
    assign load  = i_head.valid && (!r_valid || i_ready);
    assign o_pop = load && (r_sel || !i_head.data.two);
    assign n_sel = load ? !o_pop : r_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else begin
            r_sel <= n_sel;
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= r_sel ? i_head.data.b : i_head.data.a;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;
    import lt_pkg::*;

    // Run shape
    localparam int RAND_ITEMS  = 800;      // random characters after the directed part
    localparam int HOLD_CYCLES = 400;      // long output hold-off
    localparam int TAIL_CYCLES = 20;       // quiet cycles after the last token
    localparam int MAX_PRINTS  = 40;       // cap on mismatch lines
    localparam int RUN_LIMIT   = 2000000;  // time units before the run is abandoned

    // Idle mix carried by every stimulus character
    typedef enum logic [1:0] {
        MIX_FREE,      // no idling on either side
        MIX_TX_IDLE,   // sender idle with a 76% chance
        MIX_RX_STALL,  // receiver stalled with a 76% chance
        MIX_BOTH       // both sides idle with a 12% chance
    } t_idle_mix;

    typedef struct {
        t_in       beat;
        t_idle_mix mix;
        bit        drain;  // hold this beat until every expected token has come
        bit        hold;   // start the long output hold-off with this beat
    } t_char_item;

    logic  i_clk       = 1'b0;
    logic  i_rst_n     = 1'b0;
    logic  i_in_valid  = 1'b0;
    t_in   i_in_data   = '0;
    logic  i_out_ready = 1'b0;
    logic  o_in_ready;
    logic  o_out_valid;
    t_tok  o_out_data;

    line_tokenizer_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // ------------------------------------------------------------------
    // Clock and reset: one reset pulse at the start
    // ------------------------------------------------------------------
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Token predictor: its own copy of the scanner state
    // ------------------------------------------------------------------
    string      kw_names [10] = '{"print", "if", "elif", "else", "while",
                                  "input", "int", "and", "or", "not"};
    t_mode      tk_mode   = M_IDLE;
    logic [7:0] tk_word [WORD_MAX];
    int         tk_wcount = 0;
    logic [7:0] tk_quote  = '0;
    logic [7:0] tk_op     = '0;
    int         tk_start  = 0;
    int         tk_col    = 0;

    t_tok step_toks[$];     // tokens caused by the character being predicted
    t_tok tok_expect_q[$];  // tokens still owed by the block, oldest first

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_wordch(logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == CH_UNDER;
    endfunction

    function automatic bit is_space(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // Length of the open token when its last character sits at last_col
    function automatic int span_to(int last_col);
        return last_col >= tk_start ? last_col - tk_start + 1 : 1;
    endfunction

    // Keyword table position of the captured word, zero for a plain name
    function automatic logic [3:0] keyword_number();
        string w;
        bit    same;
        for (int k = 0; k < 10; k++) begin
            w = kw_names[k];
            if (w.len() == tk_wcount) begin
                same = 1'b1;
                for (int j = 0; j < tk_wcount; j++) begin
                    if (w[j] != tk_word[j]) same = 1'b0;
                end
                if (same) return 4'(k + 1);
            end
        end
        return 4'd0;
    endfunction

    task automatic add_tok(t_cat cat, int start, int len, logic [3:0] idx);
        t_tok t;
        t.category    = cat;
        t.start_col   = COL_W'(start);
        t.tok_len     = LEN_W'(len);
        t.word_index  = idx;
        t.end_of_line = 1'b0;
        t.last_of_run = 1'b0;
        step_toks = {step_toks, t};
    endtask

    // Report the open token, whose last character is at last_col, and go idle
    task automatic close_token(int last_col);
        logic [3:0] idx;
        case (tk_mode)
            M_NUM:  add_tok(CAT_NUMBER, tk_start, span_to(last_col), 4'd0);
            M_WORD: begin
                idx = keyword_number();
                add_tok(idx == 4'd0 ? CAT_IDENT : (idx <= LAST_KW ? CAT_KEYWORD : CAT_LOGICAL),
                        tk_start, span_to(last_col), idx);
            end
            M_STR:  add_tok(CAT_STRING, tk_start, span_to(last_col), 4'd0);
            M_REM:  add_tok(CAT_COMMENT, tk_start, span_to(last_col), 4'd0);
            M_IND:  add_tok(CAT_INDENT, tk_start, span_to(last_col), 4'd0);
            M_OP:   add_tok(tk_op == CH_EQ ? CAT_ASSIGN :
                            (tk_op == CH_BANG ? CAT_UNKNOWN : CAT_RELATION),
                            tk_start, 1, 4'd0);
            default: ;
        endcase
        tk_mode = M_IDLE;
    endtask

    // Advance the predictor by one accepted character and queue its tokens
    task automatic tokenize_char(t_in b);
        logic [7:0] c;
        int         cur;
        int         prev;
        bit         used;
        c    = b.ch;
        cur  = tk_col;
        prev = cur > tk_start ? cur - 1 : tk_start;
        used = 1'b0;
        step_toks.delete();

        // Extend or close the open token
        case (tk_mode)
            M_NUM: begin
                if (is_digit(c)) used = 1'b1;
                else close_token(prev);
            end
            M_WORD: begin
                if (is_wordch(c)) begin
                    used = 1'b1;
                    if (tk_wcount < WORD_MAX) tk_word[tk_wcount] = c;
                    if (tk_wcount < WORD_MAX + 1) tk_wcount++;
                end else begin
                    close_token(prev);
                end
            end
            M_STR: begin
                used = 1'b1;
                if (c == tk_quote) close_token(cur);
            end
            M_REM: used = 1'b1;
            M_IND: begin
                if (is_space(c)) used = 1'b1;
                else close_token(prev);
            end
            M_OP: begin
                if (c == CH_EQ) begin
                    used = 1'b1;
                    add_tok(CAT_RELATION, tk_start, 2, 4'd0);
                    tk_mode = M_IDLE;
                end else begin
                    close_token(prev);
                end
            end
            default: tk_mode = M_IDLE;
        endcase

        // Start a new token with a character the open one did not take
        if (!used) begin
            if (is_digit(c)) begin
                tk_mode  = M_NUM;
                tk_start = cur;
            end else if (is_alpha(c) || c == CH_UNDER) begin
                tk_mode    = M_WORD;
                tk_start   = cur;
                tk_word[0] = c;
                tk_wcount  = 1;
            end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
                tk_mode  = M_STR;
                tk_start = cur;
                tk_quote = c;
            end else if (c == CH_LPAREN) begin
                add_tok(CAT_LPAREN, cur, 1, 4'd0);
            end else if (c == CH_RPAREN) begin
                add_tok(CAT_RPAREN, cur, 1, 4'd0);
            end else if (c == CH_COLON) begin
                add_tok(CAT_COLON, cur, 1, 4'd0);
            end else if (c == CH_COMMA) begin
                add_tok(CAT_COMMA, cur, 1, 4'd0);
            end else if (c == CH_HASH) begin
                tk_mode  = M_REM;
                tk_start = cur;
            end else if (is_space(c)) begin
                // only whitespace at column zero opens an indent
                if (cur == 0) begin
                    tk_mode  = M_IND;
                    tk_start = cur;
                end
            end else if (c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT}) begin
                add_tok(CAT_ARITH, cur, 1, 4'd0);
            end else if (c inside {CH_LT, CH_GT, CH_EQ, CH_BANG}) begin
                // may pair with a following '='
                tk_mode  = M_OP;
                tk_start = cur;
                tk_op    = c;
            end else begin
                add_tok(CAT_UNKNOWN, cur, 1, 4'd0);
            end
        end

        // Close everything at the line end; otherwise advance the saturating column
        if (b.line_end) begin
            close_token(cur);
            tk_col = 0;
        end else begin
            tk_col = cur < COL_MAX ? cur + 1 : COL_MAX;
        end

        if (step_toks.size() != 0) begin
            step_toks[step_toks.size() - 1].last_of_run = 1'b1;
            step_toks[step_toks.size() - 1].end_of_line = b.line_end;
        end
        tok_expect_q = {tok_expect_q, step_toks};
    endtask

    // ------------------------------------------------------------------
    // Stimulus store and line builders
    // ------------------------------------------------------------------
    t_char_item char_q[$];
    logic [7:0] line_buf[$];
    int         line_count = 0;
    string      wordchars = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz_0123456789";

    // Append one byte to the line being built
    task automatic put_byte(logic [7:0] c);
        line_buf = {line_buf, c};
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endtask

    // Turn line_buf into character beats; line_end goes on the last one
    task automatic push_line(t_idle_mix mix, bit drain, bit hold);
        t_char_item it;
        for (int i = 0; i < line_buf.size(); i++) begin
            it.beat.ch       = line_buf[i];
            it.beat.line_end = (i == line_buf.size() - 1);
            it.mix           = mix;
            it.drain         = drain && (i == 0);
            it.hold          = hold && (i == 0);
            char_q = {char_q, it};
        end
        line_count++;
    endtask

    // Append a line of mostly well-formed random tokens to line_buf
    task automatic build_clean_line(bit allow_comment);
        int         pieces;
        int         len;
        logic [7:0] q;
        logic [7:0] c;
        string      s;
        bit         stop;
        stop = 1'b0;
        // leading whitespace becomes an indent token
        if ($urandom_range(0, 9) < 4) begin
            repeat ($urandom_range(1, 4))
                put_byte($urandom_range(0, 3) == 0 ? CH_TAB : CH_SPACE);
        end
        pieces = $urandom_range(1, 7);
        for (int p = 0; p < pieces && !stop; p++) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    // keyword, sometimes with one more word character to miss the table
                    push_text(kw_names[$urandom_range(0, 9)]);
                    if ($urandom_range(0, 3) == 0)
                        put_byte(wordchars[$urandom_range(0, 62)]);
                end
                2, 7: begin
                    len = $urandom_range(1, 8);
                    put_byte(wordchars[$urandom_range(0, 52)]);
                    repeat (len - 1) put_byte(wordchars[$urandom_range(0, 62)]);
                end
                3: begin
                    repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(48, 57)));
                end
                4: begin
                    q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
                    put_byte(q);
                    repeat ($urandom_range(0, 6)) begin
                        do c = 8'($urandom_range(32, 126)); while (c == q);
                        put_byte(c);
                    end
                    // leave the last string open now and then
                    if (p != pieces - 1 || $urandom_range(0, 3) != 0) put_byte(q);
                end
                5: begin
                    s = "()%:,+-*/";
                    put_byte(s[$urandom_range(0, s.len() - 1)]);
                end
                6: begin
                    s = "<>=!";
                    put_byte(s[$urandom_range(0, 3)]);
                    if ($urandom_range(0, 1)) put_byte(CH_EQ);
                end
                8: begin
                    if (allow_comment) begin
                        // comment swallows the rest of the line
                        put_byte(CH_HASH);
                        repeat ($urandom_range(0, 8)) put_byte(8'($urandom_range(0, 255)));
                        stop = 1'b1;
                    end else begin
                        repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(48, 57)));
                    end
                end
                default: put_byte(8'($urandom_range(128, 255)));
            endcase
            if (!stop) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: ;
                    4, 5, 6, 7: put_byte(CH_SPACE);
                    8:          put_byte(CH_TAB);
                    default:    repeat ($urandom_range(1, 3))
                                    put_byte(8'($urandom_range(9, 13)));
                endcase
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: offer character beats from char_q
    // ------------------------------------------------------------------
    logic      rx_hold_req = 1'b0;
    t_idle_mix rx_mix      = MIX_FREE;
    logic      all_drained = 1'b1;

    always @(posedge i_clk) begin
        t_char_item it;
        logic       nv;
        t_in        nd;
        logic       nh;
        t_idle_mix  nm;
        bit         gap;
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_in_data   <= '0;
            rx_hold_req <= 1'b0;
            rx_mix      <= MIX_FREE;
        end else begin
            nv = i_in_valid;
            nd = i_in_data;
            nh = 1'b0;
            nm = rx_mix;
            // Hold the beat until it is taken; then pick the next one
            if (!i_in_valid || o_in_ready) begin
                nv = 1'b0;
                if (char_q.size() != 0) begin
                    it = char_q[0];
                    case (it.mix)
                        MIX_TX_IDLE: gap = ($urandom_range(0, 99) < 76);
                        MIX_BOTH:    gap = ($urandom_range(0, 99) < 12);
                        default:     gap = 1'b0;
                    endcase
                    // A drain beat waits for a quiet input channel and an empty token store
                    if (it.drain && (i_in_valid || !all_drained)) gap = 1'b1;
                    if (!gap) begin
                        void'(char_q.pop_front());
                        nv = 1'b1;
                        nd = it.beat;
                        nh = it.hold;
                        nm = it.mix;
                    end
                end
            end
            i_in_valid  <= nv;
            i_in_data   <= nd;
            rx_hold_req <= nh;
            rx_mix      <= nm;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: long hold-off counter and random stalls
    // ------------------------------------------------------------------
    int hold_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (rx_hold_req) begin
            hold_left <= HOLD_CYCLES;
        end
    end

    always @(posedge i_clk) begin
        bit stall;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            case (rx_mix)
                MIX_RX_STALL: stall = ($urandom_range(0, 99) < 76);
                MIX_BOTH:     stall = ($urandom_range(0, 99) < 12);
                default:      stall = 1'b0;
            endcase
            i_out_ready <= (hold_left == 0) && !stall;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on each character beat, check each token beat
    // ------------------------------------------------------------------
    int err_count   = 0;
    int chars_taken = 0;
    int toks_seen   = 0;

    task automatic report_mismatch(string what, int got, int want);
        err_count++;
        if (err_count <= MAX_PRINTS)
            $display("MISMATCH token %0d %s: got %0d expected %0d", toks_seen, what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_tok want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                tokenize_char(i_in_data);
                chars_taken++;
            end
            if (o_out_valid && i_out_ready) begin
                if (tok_expect_q.size() == 0) begin
                    report_mismatch("unexpected token, category", o_out_data.category, -1);
                end else begin
                    want = tok_expect_q.pop_front();
                    if (o_out_data.category !== want.category)
                        report_mismatch("category", o_out_data.category, want.category);
                    if (o_out_data.start_col !== want.start_col)
                        report_mismatch("start_col", o_out_data.start_col, want.start_col);
                    if (o_out_data.tok_len !== want.tok_len)
                        report_mismatch("tok_len", o_out_data.tok_len, want.tok_len);
                    if (o_out_data.word_index !== want.word_index)
                        report_mismatch("word_index", o_out_data.word_index, want.word_index);
                    if (o_out_data.end_of_line !== want.end_of_line)
                        report_mismatch("end_of_line", o_out_data.end_of_line, want.end_of_line);
                    if (o_out_data.last_of_run !== want.last_of_run)
                        report_mismatch("last_of_run", o_out_data.last_of_run, want.last_of_run);
                end
                toks_seen++;
            end
            all_drained <= (tok_expect_q.size() == 0);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus fill and end of run
    // ------------------------------------------------------------------
    initial begin
        int        rand_items;
        int        free_until;
        int        phase;
        int        last_phase;
        int        r;
        bit        hold_done;
        bit        long_cmt_done;
        bit        long_mix_done;
        bit        drain;
        bit        hold;
        t_idle_mix mix;

        rand_items    = 0;
        free_until    = 0;
        last_phase    = -1;
        hold_done     = 1'b0;
        long_cmt_done = 1'b0;
        long_mix_done = 1'b0;

        // Directed: indent, keyword, name, paired relational, number, colon
        line_buf.delete();
        push_text("\tif a>=9:");
        push_line(MIX_FREE, 1'b0, 1'b0);
        // Lone '<' and '>', "!=", punctuation, arithmetic, string open at line end
        line_buf.delete();
        push_text("<>!=(,)%'q");
        push_line(MIX_FREE, 1'b0, 1'b0);
        // Lone '=', top and bottom bytes as unknowns, lone '!', trailing skipped space
        line_buf.delete();
        push_text("=");
        put_byte(8'hFF);
        put_byte(8'h00);
        push_text("! ");
        push_line(MIX_FREE, 1'b0, 1'b0);
        // Comment running to the line end
        line_buf.delete();
        push_text("#c");
        push_line(MIX_FREE, 1'b0, 1'b0);

        // Random lines: mostly well formed, some broken, some pure noise
        while (rand_items < RAND_ITEMS) begin
            line_buf.delete();
            hold  = 1'b0;
            phase = (rand_items / 100) % 4;
            mix   = t_idle_mix'(phase);
            drain = (phase != last_phase);
            last_phase = phase;
            // Hold the output off while the sender keeps offering at full rate
            if (!hold_done && rand_items >= 350) begin
                hold       = 1'b1;
                hold_done  = 1'b1;
                free_until = rand_items + 60;
            end
            if (rand_items < free_until) mix = MIX_FREE;

            if (!long_cmt_done && rand_items >= 150) begin
                // Comment from column zero past the saturation point: longest length
                long_cmt_done = 1'b1;
                put_byte(CH_HASH);
                repeat (261) put_byte(8'($urandom_range(0, 255)));
            end else if (!long_mix_done && rand_items >= 550) begin
                // Tokens running on past the saturated column
                long_mix_done = 1'b1;
                while (line_buf.size() < 275) begin
                    build_clean_line(1'b0);
                    put_byte(CH_SPACE);
                end
            end else begin
                r = $urandom_range(0, 19);
                if (r < 15) begin
                    build_clean_line(1'b1);
                end else if (r < 17) begin
                    build_clean_line(1'b1);
                    repeat ($urandom_range(1, 2))
                        line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
                end else begin
                    repeat ($urandom_range(1, 10)) put_byte(8'($urandom_range(0, 255)));
                end
            end
            push_line(mix, drain, hold);
            rand_items += line_buf.size();
        end

        // Wait for every beat to go in and every token to come out
        while (char_q.size() != 0 || i_in_valid) @(negedge i_clk);
        while (tok_expect_q.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Run covered %0d characters in %0d lines and checked %0d tokens.",
                 chars_taken, line_count, toks_seen);
        $display("Idle mixes: none, sender 76%%, receiver 76%%, both 12%%; one %0d-cycle %s",
                 HOLD_CYCLES, "output hold-off and drain pauses between phases.");
        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Abandon a run that stops making progress
    initial begin
        #RUN_LIMIT;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: line_tokenizer_core.f
sv/lt_pkg.sv
sv/lt_front.sv
sv/lt_queue.sv
sv/lt_back.sv
sv/line_tokenizer_core.sv
tb/sv/tb_top.sv
